// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  `ASSERT_PROP(lbl, (pre) |=> (post), msg)
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/fdprc_pkg.sv =====
// Constants for the 4D plane rotation chain.
// No dependencies.
package fdprc_pkg;

  localparam int NUM_ROT    = 6;
  localparam int NUM_CRD    = 4;
  localparam int COEF_W     = 16;
  localparam int ROT_W      = 2 * COEF_W;
  localparam int FRAC_SHIFT = 14;
  localparam int CFG_IDX_W  = 3;

  typedef logic [ROT_W-1:0] rot_reg_t;

  localparam rot_reg_t ROT_RESET = 32'h4000_0000;

  // Coordinate codes and plane pairs of each rotation.
  localparam int CRD_X = 0;
  localparam int CRD_Y = 1;
  localparam int CRD_Z = 2;
  localparam int CRD_W = 3;

  localparam int PLANE_A [NUM_ROT] = '{CRD_X, CRD_Y, CRD_Z, CRD_X, CRD_Y, CRD_X};
  localparam int PLANE_B [NUM_ROT] = '{CRD_Y, CRD_Z, CRD_W, CRD_Y, CRD_Z, CRD_Y};

endpackage

// ===== src/four_d_plane_rotation_chain_top.sv =====
// Top level of the 4D plane rotation chain: six pipelined plane rotations.
// Depends on fdprc_pkg and assert_macros.svh.
//
// Usage:
//   The slave stream takes one vertex per request; tdata holds x, y, z, w in
//   signed Q4.12, x in the lowest bits. The master stream returns the rotated
//   and projected x and y, saturated to the coordinate range.
//   Six cosine/sine pairs (Q2.14, cosine in the upper half) are written over
//   the cfg port while no vertex is in flight; index 0..5 selects the
//   rotation, other indexes are dropped.
// Pipeline: 12 register stages, two per rotation (products, then
//   sum/round/saturate); an accepted request enters the first stage and
//   m_axis_tvalid follows the valid bit of the last stage.
// Throughput: one vertex per cycle unless stalled; one vertex per stage.
// Reset: all stages empty, every rotation set to cos = 1.0, sin = 0.
// Stall: a stage holds while the next one is full and stalled; empty stages
//   keep filling, so s_axis_tready drops only once the whole pipe is full.
module four_d_plane_rotation_chain_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // in_x, in_y, in_z, in_w (lowest bits first)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // out_x, out_y (lowest bits first), zero padded
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  input  logic                                    cfg_we_i,
  input  logic [fdprc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fdprc_pkg::ROT_W-1:0]             cfg_data_i
);
  import fdprc_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int OUT_W  = ((2*CW+7)/8)*8;
  localparam int PROD_W = CW + COEF_W;
  localparam int ACC_W  = CW + COEF_W + 2;
  localparam int NSTG   = 2 * NUM_ROT;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] CRD_MAX =
    signed'({{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] CRD_MIN = ~CRD_MAX;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] q;
    q = (acc + RND_HALF) >>> FRAC_SHIFT;
    if (q > CRD_MAX) begin
      q = CRD_MAX;
    end else if (q < CRD_MIN) begin
      q = CRD_MIN;
    end
    return q[CW-1:0];
  endfunction

  rot_reg_t                  rot_q [NUM_ROT];
  logic [NSTG-1:0]           valid_q;
  logic [NSTG:0]             stg_ready;
  logic signed [CW-1:0]      src    [NUM_ROT][NUM_CRD];
  logic signed [CW-1:0]      pass_q [NUM_ROT][NUM_CRD];
  logic signed [PROD_W-1:0]  prd_d  [NUM_ROT][NUM_CRD];
  logic signed [PROD_W-1:0]  prd_q  [NUM_ROT][NUM_CRD];
  logic signed [CW-1:0]      vec_d  [NUM_ROT][NUM_CRD];
  logic signed [CW-1:0]      vec_q  [NUM_ROT][NUM_CRD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROT; r++) begin
        rot_q[r] <= ROT_RESET;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_ROT))) begin
      rot_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    stg_ready[NSTG] = m_axis_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      stg_ready[k] = !valid_q[k] || stg_ready[k+1];
    end
  end

  assign s_axis_tready = stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stg_ready[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CRD; i++) begin
      src[0][i] = signed'(s_axis_tdata[i*CW +: CW]);
    end
    for (int r = 1; r < NUM_ROT; r++) begin
      for (int i = 0; i < NUM_CRD; i++) begin
        src[r][i] = vec_q[r-1][i];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROT; r++) begin
      prd_d[r][0] = signed'(rot_q[r][ROT_W-1:COEF_W]) * src[r][PLANE_A[r]];
      prd_d[r][1] = signed'(rot_q[r][COEF_W-1:0])     * src[r][PLANE_B[r]];
      prd_d[r][2] = signed'(rot_q[r][COEF_W-1:0])     * src[r][PLANE_A[r]];
      prd_d[r][3] = signed'(rot_q[r][ROT_W-1:COEF_W]) * src[r][PLANE_B[r]];
      for (int i = 0; i < NUM_CRD; i++) begin
        vec_d[r][i] = pass_q[r][i];
      end
      vec_d[r][PLANE_A[r]] = round_sat(ACC_W'(prd_q[r][0]) - ACC_W'(prd_q[r][1]));
      vec_d[r][PLANE_B[r]] = round_sat(ACC_W'(prd_q[r][2]) + ACC_W'(prd_q[r][3]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NUM_ROT; r++) begin
      if (stg_ready[2*r]) begin
        pass_q[r] <= src[r];
        prd_q[r]  <= prd_d[r];
      end
      if (stg_ready[2*r+1]) begin
        vec_q[r] <= vec_d[r];
      end
    end
  end

  assign m_axis_tvalid = valid_q[NSTG-1];
  assign m_axis_tdata  = OUT_W'({vec_q[NUM_ROT-1][CRD_Y], vec_q[NUM_ROT-1][CRD_X]});

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_fills_first, s_axis_tvalid && s_axis_tready, valid_q[0], "request lost")
  `ASSERT_PROP(a_busy_means_full, !s_axis_tready |-> valid_q[0], "stall with stage 0 empty")
  `ASSERT_NEXT(a_stall_keeps_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result lost")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for four_d_plane_rotation_chain_top: streams vertices through the
// six-rotation chain under random stalls and checks each projected x/y against a local model.
// Depends on fdprc_pkg and the top-level RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fdprc_pkg::*;

  localparam int     COORD_WIDTH = 16;
  localparam int     LATENCY     = 12;
  localparam int     NUM_PHASE   = 11;
  localparam int     RAND_PER_PH = 82;
  localparam int     WDOG_LIMIT  = 3000;
  localparam longint CRD_MAX     = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CRD_MIN     = -CRD_MAX - 1;
  localparam longint ROUND_HALF  = longint'(1) <<< (FRAC_SHIFT - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] w;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] x;
  } proj_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  vertex_t              s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  rot_reg_t             cfg_data_i    = '0;

  vertex_t  vertex_q [$];
  proj_t    proj_q [$];
  rot_reg_t coef_mdl [NUM_ROT];
  bit       vtx_taken = 1'b0;
  bit       gap_free  = 1'b0;
  int       err_cnt   = 0;
  int       idle_cyc  = 0;

  vertex_t dir_vtx [6] = '{
    64'h0000_0000_0000_0000,
    64'h7FFF_7FFF_7FFF_7FFF,
    64'h8000_8000_8000_8000,
    64'h8000_7FFF_8000_7FFF,
    64'h7FFF_8000_7FFF_8000,
    64'hFFFD_0003_FFFF_0001
  };

  four_d_plane_rotation_chain_top #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint round_sat(longint acc);
    longint q;
    q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
    if (q > CRD_MAX) return CRD_MAX;
    if (q < CRD_MIN) return CRD_MIN;
    return q;
  endfunction

  function automatic proj_t rotate_and_project(vertex_t v);
    longint                   crd [NUM_CRD];
    longint                   c, s, a, b;
    logic signed [COEF_W-1:0] cf, sn;
    proj_t                    r;
    crd[CRD_X] = v.x;
    crd[CRD_Y] = v.y;
    crd[CRD_Z] = v.z;
    crd[CRD_W] = v.w;
    for (int i = 0; i < NUM_ROT; i++) begin
      cf = coef_mdl[i][ROT_W-1:COEF_W];
      sn = coef_mdl[i][COEF_W-1:0];
      c  = cf;
      s  = sn;
      a  = crd[PLANE_A[i]];
      b  = crd[PLANE_B[i]];
      crd[PLANE_A[i]] = round_sat(c * a - s * b);
      crd[PLANE_B[i]] = round_sat(s * a + c * b);
    end
    r.x = crd[CRD_X][COORD_WIDTH-1:0];
    r.y = crd[CRD_Y][COORD_WIDTH-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  task automatic write_rot(input int idx, input rot_reg_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[CFG_IDX_W-1:0];
    cfg_data_i <= val;
    if (idx < NUM_ROT) coef_mdl[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // queue random vertices, then hold until every request has its result back
  task automatic run_phase(input int n_items);
    logic [COORD_WIDTH-1:0] crd [NUM_CRD];
    int                     k;
    repeat (n_items) begin
      for (int j = 0; j < NUM_CRD; j++) begin
        k = $urandom_range(0, 9);
        if (k < 6) crd[j] = COORD_WIDTH'($urandom);
        else if (k < 8) crd[j] = COORD_WIDTH'($urandom_range(0, 128) - 64);
        else if (k == 8) crd[j] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else crd[j] = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      end
      vertex_q.push_back({crd[CRD_W], crd[CRD_Z], crd[CRD_Y], crd[CRD_X]});
    end
    while (vertex_q.size() != 0 || proj_q.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
  endtask

  // driver: hold a request until taken, then advance or idle
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || vtx_taken) begin
      if (vertex_q.size() != 0 && (gap_free || $urandom_range(0, 99) >= 16)) begin
        s_axis_tdata  <= vertex_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= gap_free || ($urandom_range(0, 99) >= 16);
  end

  // monitor: predict on each taken request, check each returned result
  always @(posedge clk_i) begin
    proj_t got, want;
    vtx_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (vtx_taken) proj_q.push_back(rotate_and_project(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (proj_q.size() == 0) begin
        flag_mismatch("unexpected result x", got.x, 0);
      end else begin
        want = proj_q.pop_front();
        if (got.x !== want.x) flag_mismatch("out_x", got.x, want.x);
        if (got.y !== want.y) flag_mismatch("out_y", got.y, want.y);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rot_reg_t               val;
    logic [COEF_W-1:0]      cf, sn;
    int                     k;
    for (int i = 0; i < NUM_ROT; i++) coef_mdl[i] = ROT_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_vtx[i]) vertex_q.push_back(dir_vtx[i]);
    run_phase(0);

    for (int ph = 0; ph < NUM_PHASE; ph++) begin
      for (int i = 0; i < NUM_ROT; i++) begin
        case (ph)
          0: val = {16'h7FFF, 16'h7FFF};
          1: val = {16'h8000, 16'h8000};
          2: val = '0;
          3: val = {16'h2000, 16'h0000};
          4: val = {16'h8000, 16'h7FFF};
          5: val = 32'hFFFF_FFFF;
          default: begin
            k = $urandom_range(0, 3);
            if (k == 0) begin
              cf = COEF_W'($urandom);
              sn = COEF_W'($urandom);
            end else if (k == 1) begin
              case ($urandom_range(0, 5))
                0: {cf, sn} = {16'd16384, 16'd0};
                1: {cf, sn} = {16'd0, 16'd16384};
                2: {cf, sn} = {16'd11585, 16'd11585};
                3: {cf, sn} = {16'd14189, 16'd8192};
                4: {cf, sn} = {16'd8192, 16'd14189};
                default: {cf, sn} = {16'd15137, 16'd6270};
              endcase
              if ($urandom_range(0, 1)) cf = -cf;
              if ($urandom_range(0, 1)) sn = -sn;
            end else if (k == 2) begin
              cf = COEF_W'($urandom_range(0, 32768) - 16384);
              sn = COEF_W'($urandom_range(0, 32768) - 16384);
            end else begin
              cf = 16'h4000;
              sn = COEF_W'($urandom_range(0, 512) - 256);
            end
            val = {cf, sn};
          end
        endcase
        write_rot(i, val);
      end
      // indexes past the last rotation must be dropped
      if (ph == 6 || ph == 9) begin
        write_rot(NUM_ROT, $urandom);
        write_rot(NUM_ROT + 1, $urandom);
      end
      gap_free = (ph == 8);
      if (ph == 0 || ph == 1 || ph == 3) foreach (dir_vtx[i]) vertex_q.push_back(dir_vtx[i]);
      run_phase(RAND_PER_PH);
    end
    gap_free = 1'b0;

    repeat (LATENCY + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== four_d_plane_rotation_chain_top.f =====
+incdir+src
src/fdprc_pkg.sv
src/four_d_plane_rotation_chain_top.sv
sim/tb_top.sv
